>>> rtl/core/wcc_pkg.sv
// Shared types and constants for the wall collision checker.
// Used by the channel interfaces and every module of the block.
`timescale 1ns / 1ps

package wcc_pkg;

  localparam int WALLS_W        = 6;
  localparam int CLR_W          = 12;
  localparam int IDX_W          = 6;
  localparam int REQ_W          = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int LC2_W          = 2 * CLR_W;
  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_COORD_BITS = 20;

  localparam logic [WALLS_W-1:0] RST_WALLS  = 6'd46;
  localparam logic [CLR_W-1:0]   RST_CORNER = 12'd512;
  localparam logic [CLR_W-1:0]   RST_LINE   = 12'd1536;
  localparam int                 RST_VIEW_X = 76800;
  localparam int                 RST_VIEW_Z = 65536;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_MOVE   = 2'd1,
    REQ_SIGHT  = 2'd2,
    REQ_SETPOS = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WALLS  = 2'd0,
    CFG_CORNER = 2'd1,
    CFG_LINE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {T_IDLE, T_BUSY, T_DONE} top_state_t;

  typedef enum logic [1:0] {E_IDLE, E_START, E_FILL, E_RUN} eng_state_t;

  // one micro step per cycle of a wall pass
  typedef enum logic [4:0] {
    K_CX2, K_CZ2, K_CC,
    K_C0, K_C1, K_L0, K_L1,
    K_D10, K_D11, K_D20, K_D21,
    K_Q0, K_Q1, K_Q2, K_Q3, K_Q4, K_Q5,
    K_S10, K_S11, K_S20, K_S21, K_S30, K_S31, K_S40, K_S41,
    K_W0, K_W1, K_DEC
  } step_t;

  typedef enum logic [3:0] {
    TAG_NONE, TAG_LC2, TAG_CORNER, TAG_C, TAG_L2, TAG_D1, TAG_D2, TAG_Q,
    TAG_S1, TAG_S2, TAG_S3, TAG_S4
  } tag_t;

  typedef enum logic [1:0] {SH_0, SH_D, SH_2D} shift_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

  typedef struct packed {
    logic   vld;
    logic   clr;
    logic   neg;
    shift_t sh;
    tag_t   tag;
  } mac_ctl_t;

  typedef struct packed {
    logic done;
    logic blocked;
  } eng_res_t;

  // product of the two signs is strictly positive
  function automatic logic same_pos(input sign_t a, input sign_t b);
    return !a.zero && !b.zero && (a.neg == b.neg);
  endfunction

endpackage

>>> rtl/core/wcc_if.sv
// Valid/ready channel interfaces of the wall collision checker.
// Depends on wcc_pkg for field widths.
`timescale 1ns / 1ps

interface wcc_in_if import wcc_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic [REQ_W-1:0]             req_type;
  logic [IDX_W-1:0]             point_index;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, req_type, point_index, coord_x, coord_z, input ready);
  modport sink   (input valid, req_type, point_index, coord_x, coord_z, output ready);
endinterface

interface wcc_out_if import wcc_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         blocked;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_z;

  modport source (output valid, blocked, pos_x, pos_z, input ready);
  modport sink   (input valid, blocked, pos_x, pos_z, output ready);
endinterface

interface wcc_cfg_if import wcc_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CLR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/wcc_point_mem.sv
// Wall point store: one write port, one registered read port.
// Depends on wcc_pkg only for default sizes.
`timescale 1ns / 1ps

module wcc_point_mem import wcc_pkg::*; #(
  parameter int DEPTH = DEF_MAX_POINTS,
  parameter int DW    = 2 * DEF_COORD_BITS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/wcc_mac.sv
// Shared multiply-accumulate unit: registered product, then a wide add.
// Depends on wcc_pkg for the control word and result tags.
`timescale 1ns / 1ps

module wcc_mac import wcc_pkg::*; #(
  parameter int D  = DEF_COORD_BITS + 1,
  parameter int MW = D + 2,
  parameter int AW = 4 * D
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mac_ctl_t             op,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [AW-1:0] acc,
  output tag_t                 tag_done
);

  logic signed [2*MW-1:0] prod_r;
  mac_ctl_t               c1_r;
  tag_t                   tag_r;
  logic signed [AW-1:0]   acc_r;
  logic signed [AW-1:0]   acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r  <= '0;
      tag_r <= TAG_NONE;
    end else begin
      c1_r  <= op;
      tag_r <= c1_r.vld ? c1_r.tag : TAG_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    if (c1_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    logic signed [AW-1:0] term;
    logic signed [AW-1:0] base;
    term = AW'(prod_r);
    case (c1_r.sh)
      SH_D:    term = term <<< D;
      SH_2D:   term = term <<< (2 * D);
      default: term = term;
    endcase
    if (c1_r.neg) begin
      term = -term;
    end
    base    = c1_r.clr ? '0 : acc_r;
    acc_nxt = base + term;
  end

  assign acc      = acc_r;
  assign tag_done = tag_r;

endmodule

>>> rtl/core/wcc_seq.sv
// Wall pass sequencer: walks the walls, drives the shared MAC and keeps
// the sign flags of each test. Depends on wcc_pkg and wcc_mac.
`timescale 1ns / 1ps

module wcc_seq import wcc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic                          move,
  input  logic signed [COORD_BITS-1:0]  tx,
  input  logic signed [COORD_BITS-1:0]  tz,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  pz,
  input  logic [WALLS_W-1:0]            wall_count,
  input  logic [CLR_W-1:0]              corner_clr,
  input  logic [CLR_W-1:0]              line_clr,
  output logic                          rd_en,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
  input  logic [2*COORD_BITS-1:0]       rd_data,
  output eng_res_t                      res
);

  localparam int CB = COORD_BITS;
  localparam int D  = CB + 1;
  localparam int MW = (D + 2 > LC2_W + 1) ? D + 2 : LC2_W + 1;
  localparam int AW = (4 * D > 2 * D + LC2_W + 2) ? 4 * D : 2 * D + LC2_W + 2;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = WALLS_W + 1;

  eng_state_t           state_r, state_nxt;
  step_t                step_r;
  logic [CW-1:0]        i_r;
  logic signed [CB-1:0] p1x_r, p1z_r;
  logic signed [CB-1:0] p2x, p2z;
  logic [LC2_W-1:0]     lc2_r;
  logic [2*D-1:0]       c_r, l2_r;
  logic                 crn_r, q_r;
  sign_t                d1_r, d2_r, s1_r, s2_r, s3_r, s4_r;

  mac_ctl_t             op;
  logic signed [MW-1:0] opa, opb;
  logic signed [AW-1:0] acc;
  tag_t                 tag_done;

  logic [CW-1:0]        lim;
  logic                 wall_ok, last, blk, fin;
  logic                 bbox_hit, sight_hit, line_hit;
  logic signed [D-1:0]  dxe1, dze1, dxe2, dze2, vx, vz, ux, uz, dxp1, dzp1, dxp2, dzp2;

  wcc_mac #(.D(D), .MW(MW), .AW(AW)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .a        (opa),
    .b        (opb),
    .acc      (acc),
    .tag_done (tag_done)
  );

  function automatic logic signed [MW-1:0] sx(input logic signed [D-1:0] v);
    return MW'(v);
  endfunction

  function automatic logic signed [MW-1:0] zx(input logic [D-1:0] v);
    return $signed(MW'(v));
  endfunction

  assign p2x = $signed(rd_data[CB-1:0]);
  assign p2z = $signed(rd_data[2*CB-1:CB]);

  assign dxe1 = D'(p1x_r) - D'(tx);
  assign dze1 = D'(p1z_r) - D'(tz);
  assign dxe2 = D'(p2x) - D'(tx);
  assign dze2 = D'(p2z) - D'(tz);
  assign vx   = D'(p2x) - D'(p1x_r);
  assign vz   = D'(p2z) - D'(p1z_r);
  assign ux   = D'(tx) - D'(px);
  assign uz   = D'(tz) - D'(pz);
  assign dxp1 = D'(p1x_r) - D'(px);
  assign dzp1 = D'(p1z_r) - D'(pz);
  assign dxp2 = D'(p2x) - D'(px);
  assign dzp2 = D'(p2z) - D'(pz);

  // walls in use, clipped to the table
  assign lim = (32'(wall_count) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(wall_count);
  assign wall_ok = (32'(i_r) + 1) < MAX_POINTS;
  assign last    = (32'(i_r) + 1) >= 32'(lim);

  always_comb begin
    logic signed [CB-1:0] xmin, xmax, zmin, zmax, wxmin, wxmax, wzmin, wzmax;
    xmin  = (px < tx) ? px : tx;
    xmax  = (px < tx) ? tx : px;
    zmin  = (pz < tz) ? pz : tz;
    zmax  = (pz < tz) ? tz : pz;
    wxmin = (p1x_r < p2x) ? p1x_r : p2x;
    wxmax = (p1x_r < p2x) ? p2x : p1x_r;
    wzmin = (p1z_r < p2z) ? p1z_r : p2z;
    wzmax = (p1z_r < p2z) ? p2z : p1z_r;
    bbox_hit  = !(xmax < wxmin || wxmax < xmin || zmax < wzmin || wzmax < zmin);
    sight_hit = bbox_hit && !same_pos(s1_r, s2_r) && !same_pos(s3_r, s4_r);
    // D1 and D2 are accumulated negated
    line_hit  = q_r && (d1_r.neg || d1_r.zero) && !d2_r.neg;
    if (move) begin
      blk = crn_r || (wall_ok && (line_hit || sight_hit));
    end else begin
      blk = wall_ok && sight_hit;
    end
    fin = blk || last;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      E_IDLE:  if (go) state_nxt = E_START;
      E_START: state_nxt = (lim == '0) ? E_IDLE : E_FILL;
      E_FILL:  state_nxt = E_RUN;
      E_RUN:   if (step_r == K_DEC && fin) state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      E_START: i_r <= '0;
      E_FILL: begin
        p1x_r  <= p2x;
        p1z_r  <= p2z;
        step_r <= move ? K_CX2 : K_S10;
      end
      E_RUN: begin
        if (step_r == K_DEC) begin
          i_r    <= i_r + 1'b1;
          p1x_r  <= p2x;
          p1z_r  <= p2z;
          step_r <= move ? K_CX2 : K_S10;
        end else begin
          step_r <= step_t'(step_r + 1'b1);
        end
      end
      default: ;
    endcase
  end

  // capture results as each accumulation lands
  always_ff @(posedge clk) begin
    logic signed [AW-1:0] mag;
    sign_t                sg;
    mag     = acc[AW-1] ? -acc : acc;
    sg.neg  = acc[AW-1];
    sg.zero = (acc == '0);
    unique case (tag_done)
      TAG_LC2:    lc2_r <= acc[LC2_W-1:0];
      TAG_CORNER: crn_r <= sg.neg;
      TAG_C:      c_r   <= mag[2*D-1:0];
      TAG_L2:     l2_r  <= acc[2*D-1:0];
      TAG_D1:     d1_r  <= sg;
      TAG_D2:     d2_r  <= sg;
      TAG_Q:      q_r   <= sg.neg;
      TAG_S1:     s1_r  <= sg;
      TAG_S2:     s2_r  <= sg;
      TAG_S3:     s3_r  <= sg;
      TAG_S4:     s4_r  <= sg;
      default: ;
    endcase
  end

  // outputs: memory reads, MAC operations, result
  always_comb begin
    op       = '0;
    op.sh    = SH_0;
    op.tag   = TAG_NONE;
    opa      = '0;
    opb      = '0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    res      = '0;
    unique case (state_r)
      E_START: begin
        rd_en   = 1'b1;
        op.vld  = 1'b1;
        op.clr  = 1'b1;
        op.tag  = TAG_LC2;
        opa     = $signed(MW'(line_clr));
        opb     = $signed(MW'(line_clr));
        res.done = (lim == '0);
      end
      E_FILL: begin
        rd_en   = 1'b1;
        rd_addr = IW'(1);
      end
      E_RUN: begin
        op.vld = 1'b1;
        unique case (step_r)
          K_CX2: begin opa = sx(dxe1); opb = sx(dxe1); op.clr = 1'b1; end
          K_CZ2: begin opa = sx(dze1); opb = sx(dze1); end
          K_CC: begin
            opa = $signed(MW'(corner_clr)); opb = $signed(MW'(corner_clr));
            op.neg = 1'b1; op.tag = TAG_CORNER;
          end
          K_C0: begin opa = sx(dxe1); opb = sx(dze2); op.clr = 1'b1; end
          K_C1: begin opa = sx(dze1); opb = sx(dxe2); op.neg = 1'b1; op.tag = TAG_C; end
          K_L0: begin opa = sx(vx); opb = sx(vx); op.clr = 1'b1; end
          K_L1: begin opa = sx(vz); opb = sx(vz); op.tag = TAG_L2; end
          K_D10: begin opa = sx(dxe1); opb = sx(vx); op.clr = 1'b1; end
          K_D11: begin opa = sx(dze1); opb = sx(vz); op.tag = TAG_D1; end
          K_D20: begin opa = sx(dxe2); opb = sx(vx); op.clr = 1'b1; end
          K_D21: begin opa = sx(dze2); opb = sx(vz); op.tag = TAG_D2; end
          // c^2 from halves, minus l2 * lc^2
          K_Q0: begin opa = zx(c_r[D-1:0]); opb = zx(c_r[D-1:0]); op.clr = 1'b1; end
          K_Q1, K_Q2: begin
            opa = zx(c_r[2*D-1:D]); opb = zx(c_r[D-1:0]); op.sh = SH_D;
          end
          K_Q3: begin opa = zx(c_r[2*D-1:D]); opb = zx(c_r[2*D-1:D]); op.sh = SH_2D; end
          K_Q4: begin opa = zx(l2_r[D-1:0]); opb = $signed(MW'(lc2_r)); op.neg = 1'b1; end
          K_Q5: begin
            opa = zx(l2_r[2*D-1:D]); opb = $signed(MW'(lc2_r));
            op.sh = SH_D; op.neg = 1'b1; op.tag = TAG_Q;
          end
          K_S10: begin opa = sx(vx); opb = sx(dzp2); op.clr = 1'b1; end
          K_S11: begin opa = sx(vz); opb = sx(dxp2); op.neg = 1'b1; op.tag = TAG_S1; end
          K_S20: begin opa = sx(vx); opb = sx(dze2); op.clr = 1'b1; end
          K_S21: begin opa = sx(vz); opb = sx(dxe2); op.neg = 1'b1; op.tag = TAG_S2; end
          K_S30: begin opa = sx(ux); opb = sx(dzp2); op.clr = 1'b1; end
          K_S31: begin opa = sx(uz); opb = sx(dxp2); op.neg = 1'b1; op.tag = TAG_S3; end
          K_S40: begin opa = sx(ux); opb = sx(dzp1); op.clr = 1'b1; end
          K_S41: begin opa = sx(uz); opb = sx(dxp1); op.neg = 1'b1; op.tag = TAG_S4; end
          K_DEC: begin
            op.vld      = 1'b0;
            rd_en       = 1'b1;
            rd_addr     = IW'(32'(i_r) + 2);
            res.done    = fin;
            res.blocked = blk;
          end
          default: op.vld = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/wall_collision_checker.sv
// Top level of the wall collision checker: channels, registers, viewer.
// Depends on wcc_pkg, wcc_if, wcc_point_mem and wcc_seq.
`timescale 1ns / 1ps

// Collision and line-of-sight checker against a wall polyline in signed
// Q10.10. A move test runs corner, line and crossing tests per wall, about
// 25 products through one shared multiply-accumulate unit, and a sight
// test runs the crossing test only; both stop at the first blocking wall.
// Walls in use are min(wall_count, MAX_POINTS). The block takes one word
// at a time; a finished result waits in the output register while the next
// word is taken. Configuration must be written only while idle; the block
// itself does not enforce this.

module wall_collision_checker import wcc_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input logic       clk,
  input logic       rst_n,
  wcc_in_if.sink    in_if,
  wcc_out_if.source out_if,
  wcc_cfg_if.sink   cfg_if
);

  localparam int CB = COORD_BITS;
  localparam int IW = $clog2(MAX_POINTS);

  top_state_t           tstate_r, tstate_nxt;
  req_t                 item_type_r;
  logic signed [CB-1:0] tx_r, tz_r, vx_r, vz_r;
  logic                 blk_r;
  logic [WALLS_W-1:0]   walls_r;
  logic [CLR_W-1:0]     cc_r, lc_r;
  logic                 out_valid_r, out_blk_r;
  logic signed [CB-1:0] out_x_r, out_z_r;

  logic                 accept, go, we, fire, upd;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [2*CB-1:0]      rd_data;
  eng_res_t             res;

  assign accept = in_if.valid && in_if.ready;
  assign fire   = (tstate_r == T_DONE) && (!out_valid_r || out_if.ready);
  assign upd    = (item_type_r == REQ_SETPOS) || (item_type_r == REQ_MOVE && !blk_r);

  wcc_point_mem #(.DEPTH(MAX_POINTS), .DW(2 * CB)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (IW'(in_if.point_index)),
    .wdata ({in_if.coord_z, in_if.coord_x}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  wcc_seq #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(CB)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .move       (item_type_r == REQ_MOVE),
    .tx         (tx_r),
    .tz         (tz_r),
    .px         (vx_r),
    .pz         (vz_r),
    .wall_count (walls_r),
    .corner_clr (cc_r),
    .line_clr   (lc_r),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .res        (res)
  );

  // next state
  always_comb begin
    tstate_nxt = tstate_r;
    unique case (tstate_r)
      T_IDLE: begin
        if (accept) begin
          if (req_t'(in_if.req_type) == REQ_MOVE || req_t'(in_if.req_type) == REQ_SIGHT) begin
            tstate_nxt = T_BUSY;
          end else begin
            tstate_nxt = T_DONE;
          end
        end
      end
      T_BUSY:  if (res.done) tstate_nxt = T_DONE;
      T_DONE:  if (fire) tstate_nxt = T_IDLE;
      default: tstate_nxt = T_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_if.ready = (tstate_r == T_IDLE);
    go          = (tstate_r == T_BUSY);
    we          = accept && (req_t'(in_if.req_type) == REQ_LOAD) &&
                  (32'(in_if.point_index) < MAX_POINTS);
  end

  assign cfg_if.ready  = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.blocked = out_blk_r;
  assign out_if.pos_x   = out_x_r;
  assign out_if.pos_z   = out_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tstate_r    <= T_IDLE;
      out_valid_r <= 1'b0;
      walls_r     <= RST_WALLS;
      cc_r        <= RST_CORNER;
      lc_r        <= RST_LINE;
      vx_r        <= CB'(RST_VIEW_X);
      vz_r        <= CB'(RST_VIEW_Z);
    end else begin
      tstate_r <= tstate_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        unique case (cfg_reg_t'(cfg_if.index))
          CFG_WALLS:  walls_r <= cfg_if.data[WALLS_W-1:0];
          CFG_CORNER: cc_r    <= cfg_if.data;
          CFG_LINE:   lc_r    <= cfg_if.data;
          default: ;
        endcase
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        if (upd) begin
          vx_r <= tx_r;
          vz_r <= tz_r;
        end
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_type_r <= req_t'(in_if.req_type);
      tx_r        <= in_if.coord_x;
      tz_r        <= in_if.coord_z;
      blk_r       <= 1'b0;
    end else if (tstate_r == T_BUSY && res.done) begin
      blk_r <= res.blocked;
    end
    if (fire) begin
      out_blk_r <= blk_r;
      out_x_r   <= upd ? tx_r : vx_r;
      out_z_r   <= upd ? tz_r : vz_r;
    end
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_if.ready)
    else $error("input taken while a word is in flight");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (tstate_r == T_BUSY))
    else $error("sequencer finished outside a test");

  a_plain_free: assert property (@(posedge clk) disable iff (!rst_n)
    (tstate_r == T_DONE && (item_type_r == REQ_LOAD || item_type_r == REQ_SETPOS))
    |-> !blk_r)
    else $error("load or set position reported blocked");

  a_viewer_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (tstate_r != T_DONE) |=> ($stable(vx_r) && $stable(vz_r)))
    else $error("viewer moved outside result delivery");
`endif

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for wall_collision_checker: loads wall polylines,
// drives move, sight and set-position words, and compares every result word
// against a built-in predictor. Depends on wcc_pkg, wcc_if and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import wcc_pkg::*;

  localparam int NPTS = 64;
  localparam int CB   = 20;

  typedef struct {
    logic              blocked;
    logic [CB-1:0]     px;
    logic [CB-1:0]     pz;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wcc_in_if  #(.COORD_BITS(CB)) in_if ();
  wcc_out_if #(.COORD_BITS(CB)) out_if ();
  wcc_cfg_if cfg_if ();

  wall_collision_checker #(.MAX_POINTS(NPTS), .COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  always #10 clk = ~clk;

  // predictor state
  longint wall_x [NPTS];
  longint wall_z [NPTS];
  bit     loaded [NPTS];
  longint view_x, view_z;
  int     n_walls, clr_corner, clr_line;

  pose_t  pose_q[$];
  int     errors = 0;
  int     n_words = 0;
  int     n_blocked = 0;
  bit     relax_gaps = 0;

  // exact sign of a*d - b*c; operands fit in 22 bits so 64-bit math is exact
  function automatic int cross_sign(longint a, longint b, longint c, longint d);
    longint r;
    r = a * d - b * c;
    return (r < 0) ? -1 : (r > 0 ? 1 : 0);
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a < b ? b : a;
  endfunction

  function automatic bit sight_hit(longint ex, longint ez);
    longint x1, z1, x2, z2, vx, vz, ux, uz;
    int s1, s2;
    for (int i = 0; i < n_walls; i++) begin
      if (i + 1 >= NPTS) continue;
      x1 = wall_x[i]; z1 = wall_z[i]; x2 = wall_x[i+1]; z2 = wall_z[i+1];
      if (lmax(view_x, ex) < lmin(x1, x2) || lmax(x1, x2) < lmin(view_x, ex) ||
          lmax(view_z, ez) < lmin(z1, z2) || lmax(z1, z2) < lmin(view_z, ez))
        continue;
      vx = x2 - x1; vz = z2 - z1;
      s1 = cross_sign(vx, vz, view_x - x2, view_z - z2);
      s2 = cross_sign(vx, vz, ex - x2, ez - z2);
      if (s1 * s2 > 0) continue;
      ux = ex - view_x; uz = ez - view_z;
      s1 = cross_sign(ux, uz, x2 - view_x, z2 - view_z);
      s2 = cross_sign(ux, uz, x1 - view_x, z1 - view_z);
      if (s1 * s2 <= 0) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit move_hit(longint ex, longint ez);
    longint dx, dz, x1, z1, x2, z2, vx, vz, c, l2, lc2;
    logic [127:0] lhs, rhs, d2;
    for (int i = 0; i < n_walls && i < NPTS; i++) begin
      dx = wall_x[i] - ex; dz = wall_z[i] - ez;
      d2 = dx * dx + dz * dz;
      if (d2 < 128'(clr_corner) * 128'(clr_corner)) return 1'b1;
    end
    lc2 = longint'(clr_line) * clr_line;
    for (int i = 0; i < n_walls; i++) begin
      if (i + 1 >= NPTS) continue;
      x1 = wall_x[i]; z1 = wall_z[i]; x2 = wall_x[i+1]; z2 = wall_z[i+1];
      vx = x2 - x1; vz = z2 - z1;
      c = (x1 - ex) * (z2 - ez) - (z1 - ez) * (x2 - ex);
      if (c < 0) c = -c;
      l2 = vx * vx + vz * vz;
      lhs = 128'(c) * 128'(c);
      rhs = 128'(l2) * 128'(lc2);
      if (lhs < rhs && ((ex - x1) * vx + (ez - z1) * vz) >= 0 &&
          ((ex - x2) * vx + (ez - z2) * vz) <= 0)
        return 1'b1;
    end
    return sight_hit(ex, ez);
  endfunction

  function automatic pose_t predict_pose(req_t kind, int idx, logic [CB-1:0] cx,
                                         logic [CB-1:0] cz);
    pose_t p;
    longint x, z;
    x = longint'($signed(cx)); z = longint'($signed(cz));
    p.blocked = 1'b0;
    case (kind)
      REQ_LOAD: begin
        wall_x[idx] = x; wall_z[idx] = z; loaded[idx] = 1'b1;
      end
      REQ_MOVE: begin
        if (move_hit(x, z)) p.blocked = 1'b1;
        else begin
          view_x = x; view_z = z;
        end
      end
      REQ_SIGHT: p.blocked = sight_hit(x, z);
      default: begin
        view_x = x; view_z = z;
      end
    endcase
    p.px = CB'(view_x);
    p.pz = CB'(view_z);
    return p;
  endfunction

  // drop valid only when an idle gap is drawn
  task automatic wait_gap();
    int n;
    n = relax_gaps ? 0 : $urandom_range(0, 17);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_word(req_t kind, int idx, logic [CB-1:0] cx, logic [CB-1:0] cz);
    wait_gap();
    in_if.valid       <= 1'b1;
    in_if.req_type    <= kind;
    in_if.point_index <= IDX_W'(idx);
    in_if.coord_x     <= cx;
    in_if.coord_z     <= cz;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pose_q.push_back(predict_pose(kind, idx, cx, cz));
    n_words++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, int val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data  <= CLR_W'(val);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (r)
      CFG_WALLS:  n_walls = val & 63;
      CFG_CORNER: clr_corner = val & 4095;
      default:    clr_line = val & 4095;
    endcase
    @(posedge clk);
  endtask

  // result checker with random back-pressure
  initial begin
    pose_t e;
    int    stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = relax_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result word blocked=%0b pos=(%0d,%0d)", $time,
                 out_if.blocked, out_if.pos_x, out_if.pos_z);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (e.blocked) n_blocked++;
        if (out_if.blocked !== e.blocked) begin
          $display("%0t: blocked expected %0b actual %0b", $time, e.blocked,
                   out_if.blocked);
          errors++;
        end
        if (out_if.pos_x !== e.px) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, $signed(e.px),
                   out_if.pos_x);
          errors++;
        end
        if (out_if.pos_z !== e.pz) begin
          $display("%0t: pos_z expected %0d actual %0d", $time, $signed(e.pz),
                   out_if.pos_z);
          errors++;
        end
      end
    end
  end

  function automatic logic [CB-1:0] rnd_coord(int span);
    return CB'($urandom_range(0, 2 * span) - span);
  endfunction

  // load points 0..n with random points within span of the origin
  task automatic load_room(int n, int span);
    for (int i = 0; i <= n && i < NPTS; i++)
      send_word(REQ_LOAD, i, rnd_coord(span), rnd_coord(span));
  endtask

  task automatic test_directed();
    // box-shaped room with a zero-length wall and a touching corner
    send_word(REQ_LOAD, 0, -20'sd10240, -20'sd10240);
    send_word(REQ_LOAD, 1, 20'sd10240, -20'sd10240);
    send_word(REQ_LOAD, 2, 20'sd10240, -20'sd10240);
    send_word(REQ_LOAD, 3, 20'sd10240, 20'sd10240);
    send_word(REQ_LOAD, 4, -20'sd10240, 20'sd10240);
    send_word(REQ_LOAD, 5, -20'sd10240, -20'sd10240);
    send_word(REQ_LOAD, 63, 20'h7FFFF, 20'h80000);
    drain();
    write_reg(CFG_WALLS, 5);
    write_reg(CFG_CORNER, 512);
    write_reg(CFG_LINE, 1536);
    send_word(REQ_SETPOS, 0, 20'sd0, 20'sd0);
    send_word(REQ_MOVE, 0, 20'sd1024, 20'sd2048);
    send_word(REQ_MOVE, 0, 20'sd9800, 20'sd0);
    send_word(REQ_MOVE, 0, 20'sd20480, 20'sd0);
    send_word(REQ_SIGHT, 0, 20'sd10240, 20'sd10240);
    send_word(REQ_SIGHT, 0, 20'sd2000, -20'sd3000);
    send_word(REQ_MOVE, 0, -20'sd10000, -20'sd10000);
    send_word(REQ_SETPOS, 63, 20'h7FFFF, 20'h7FFFF);
    send_word(REQ_SIGHT, 0, 20'h80000, 20'h80000);
    send_word(REQ_MOVE, 0, 20'h80000, 20'h7FFFF);
    drain();
    write_reg(CFG_WALLS, 0);
    send_word(REQ_MOVE, 0, 20'sd0, 20'sd0);
    send_word(REQ_SIGHT, 0, 20'h7FFFF, 20'h80000);
    drain();
  endtask

  // full table with wall count 63 so the last wall reads slot 63
  task automatic test_full_table();
    load_room(63, 524287);
    drain();
    write_reg(CFG_WALLS, 63);
    write_reg(CFG_CORNER, 4095);
    write_reg(CFG_LINE, 4095);
    for (int i = 0; i < 40; i++)
      send_word(req_t'($urandom_range(1, 3)), $urandom_range(0, 63),
                CB'($urandom), CB'($urandom));
    drain();
  endtask

  task automatic test_random(int n_items);
    int walls, span;
    for (int ph = 0; ph < 6; ph++) begin
      walls = (ph == 0) ? 1 : $urandom_range(1, 12);
      span  = (ph % 2) ? 8192 : 40000;
      load_room(walls, span);
      drain();
      write_reg(CFG_WALLS, walls);
      write_reg(CFG_CORNER, (ph == 1) ? 0 : $urandom_range(0, 4095));
      write_reg(CFG_LINE, (ph == 2) ? 4095 : $urandom_range(0, 4095));
      relax_gaps = (ph == 3);
      for (int k = 0; k < n_items / 6; k++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
          send_word(REQ_MOVE, 0, rnd_coord(span), rnd_coord(span));
        else if (r < 80)
          send_word(REQ_SIGHT, $urandom_range(0, 63), rnd_coord(span), rnd_coord(span));
        else if (r < 90)
          send_word(REQ_SETPOS, 0, rnd_coord(span), rnd_coord(span));
        else if (r < 95)
          // reload a point already in use, keeps reads defined
          send_word(REQ_LOAD, $urandom_range(0, walls), rnd_coord(span),
                    rnd_coord(span));
        else
          send_word(REQ_MOVE, 0, CB'($urandom), CB'($urandom));
      end
      relax_gaps = 0;
      drain();
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = REQ_LOAD;
    in_if.point_index = '0;
    in_if.coord_x = '0;
    in_if.coord_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_WALLS;
    cfg_if.data = '0;
    n_walls = 46; clr_corner = 512; clr_line = 1536;
    view_x = 76800; view_z = 65536;
    for (int i = 0; i < NPTS; i++) begin
      wall_x[i] = 0; wall_z[i] = 0; loaded[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(1200);
    $display("covered %0d words, %0d blocked results, wall counts 0 to 63,",
             n_words, n_blocked);
    $display("clearances 0 to 4095, with random input and output stalls");
    if (errors == 0) begin
      $display("wall_collision_checker test passed");
    end else begin
      $display("wall_collision_checker test failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("wall_collision_checker test failed");
    $finish;
  end

endmodule
